>>> hdl/crce_pkg.sv
`default_nettype none

package crce_pkg;

    // Fixed widths of the external fields.
    localparam int CRC_OUT_W   = 64;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 8;
    localparam int WIDTH_SEL_W = 2;

    // Effective CRC width in bits, 8 up to 64, needs seven bits.
    localparam int EFF_W_BITS = 7;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_SELECT  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REFLECTED     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [WIDTH_SEL_W-1:0] WIDTH_SEL_RESET = 2'd2;
    localparam logic                   REFLECTED_RESET = 1'b1;

    // One queued request: a message byte and its restart flag.
    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

endpackage

`default_nettype wire

>>> hdl/configurable_crc_byte_engine.sv
`default_nettype none
// Each byte waits in the request queue; its CRC is registered into the result queue and read from there.
// One byte per cycle while the result queue has room; the eight-bit update is one XOR network.
// Queues of two entries on each side let input and output stall independently.
// Reset (asynchronous, active low) empties both queues, clears the running CRC and sets the
// registers to polynomial 0, 32-bit width, reflected order and initial value 0.
module configurable_crc_byte_engine
    import crce_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Byte input
    input  wire logic                   push,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   restart,
    output logic                        full,
    // CRC output
    output logic                        empty,
    input  wire logic                   pop,
    output logic [CRC_OUT_W-1:0]        crc_value,
    // Register writes
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        cfg_ready
);

    logic                  cmd_valid;
    item_t                 cmd;
    logic                  cmd_pop;
    logic                  refl;
    logic [MAX_WIDTH-1:0]  crc_mask;
    logic [MAX_WIDTH-1:0]  top_bit;
    logic [MAX_WIDTH-1:0]  poly_eff;
    logic [MAX_WIDTH-1:0]  init_eff;
    logic [EFF_W_BITS-1:0] byte_shift;

    // Front: registers and request queue.
    crce_front #(
        .CRC_W (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .restart    (restart),
        .full       (full),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .refl       (refl),
        .crc_mask   (crc_mask),
        .top_bit    (top_bit),
        .poly_eff   (poly_eff),
        .init_eff   (init_eff),
        .byte_shift (byte_shift)
    );

    // Back: CRC update and result queue.
    crce_back #(
        .CRC_W (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .refl       (refl),
        .crc_mask   (crc_mask),
        .top_bit    (top_bit),
        .poly_eff   (poly_eff),
        .init_eff   (init_eff),
        .byte_shift (byte_shift),
        .empty      (empty),
        .pop        (pop),
        .crc_value  (crc_value)
    );

endmodule

`default_nettype wire

>>> hdl/crce_fifo.sv
`default_nettype none

module crce_fifo
    import crce_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    // Handshake qualification.
    assign full    = (count_reg == 2'(DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; only written entries are ever read.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Occupancy never exceeds the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue occupancy beyond its depth");

    // A request taken without a pop adds exactly one entry.
    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue occupancy did not grow on push");

    // Popping the last entry with nothing arriving leaves the queue empty.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push && count_reg == 2'd1) |=> empty)
        else $error("queue not empty after last pop");

    // Pointers stay apart by exactly the occupancy.
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) == (count_reg != 2'd1))
        else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

>>> hdl/crce_front.sv
`default_nettype none

module crce_front
    import crce_pkg::*;
#(
    parameter int CRC_W = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Item side
    input  wire logic                   push,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   restart,
    output logic                        full,
    // Configuration side
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        cfg_ready,
    // Towards the engine
    output logic                        cmd_valid,
    output item_t                       cmd,
    input  wire logic                   cmd_pop,
    output logic                        refl,
    output logic [CRC_W-1:0]            crc_mask,
    output logic [CRC_W-1:0]            top_bit,
    output logic [CRC_W-1:0]            poly_eff,
    output logic [CRC_W-1:0]            init_eff,
    output logic [EFF_W_BITS-1:0]       byte_shift
);

    localparam logic [EFF_W_BITS-1:0] CRC_W_CAP = EFF_W_BITS'(CRC_W);

    logic [CRC_W-1:0]       poly_reg;
    logic [WIDTH_SEL_W-1:0] width_sel_reg;
    logic                   reflected_reg;
    logic [CRC_W-1:0]       init_reg;
    logic [EFF_W_BITS-1:0]  sel_width;
    logic [EFF_W_BITS-1:0]  eff_width;
    item_t                  in_item;
    logic [ITEM_W-1:0]      q_data;
    logic                   q_empty;

    // The register port never stalls.
    assign cfg_ready = 1'b1;

    // Register file, written by index; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg      <= '0;
            width_sel_reg <= WIDTH_SEL_RESET;
            reflected_reg <= REFLECTED_RESET;
            init_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_POLYNOMIAL:    poly_reg      <= cfg_data[CRC_W-1:0];
                REG_WIDTH_SELECT:  width_sel_reg <= cfg_data[WIDTH_SEL_W-1:0];
                REG_REFLECTED:     reflected_reg <= cfg_data[0];
                REG_INITIAL_VALUE: init_reg      <= cfg_data[CRC_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective width, capped by the synthesised CRC width, and its masks.
    always_comb
    begin
        sel_width = EFF_W_BITS'(8) << width_sel_reg;
        eff_width = (sel_width > CRC_W_CAP) ? CRC_W_CAP : sel_width;
        for (int i = 0; i < CRC_W; i++)
        begin
            crc_mask[i] = (EFF_W_BITS'(i) < eff_width);
        end
        top_bit    = crc_mask ^ (crc_mask >> 1);
        byte_shift = eff_width - EFF_W_BITS'(8);
        poly_eff   = poly_reg & crc_mask;
        init_eff   = init_reg & crc_mask;
        refl       = reflected_reg;
    end

    // Incoming requests wait in a short queue for the engine.
    always_comb
    begin
        in_item.restart   = restart;
        in_item.data_byte = data_byte;
    end

    crce_fifo #(
        .WIDTH (ITEM_W)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (in_item),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = item_t'(q_data);

endmodule

`default_nettype wire

>>> hdl/crce_back.sv
`default_nettype none

module crce_back
    import crce_pkg::*;
#(
    parameter int CRC_W = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // From the front queue
    input  wire logic                  cmd_valid,
    input  wire item_t                 cmd,
    output logic                       cmd_pop,
    input  wire logic                  refl,
    input  wire logic [CRC_W-1:0]      crc_mask,
    input  wire logic [CRC_W-1:0]      top_bit,
    input  wire logic [CRC_W-1:0]      poly_eff,
    input  wire logic [CRC_W-1:0]      init_eff,
    input  wire logic [EFF_W_BITS-1:0] byte_shift,
    // Result side
    output logic                       empty,
    input  wire logic                  pop,
    output logic [CRC_OUT_W-1:0]       crc_value
);

    logic [CRC_W-1:0] running_crc_reg;
    logic [CRC_W-1:0] running_crc_next;
    logic [CRC_W-1:0] crc_start;
    logic [CRC_W-1:0] out_data;
    logic             out_full;
    logic             fire;

    // Eight shift-and-XOR steps for one byte, in either bit order.
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]      crc_in,
        input logic [7:0]            byte_in,
        input logic                  refl_in,
        input logic [CRC_W-1:0]      mask_in,
        input logic [CRC_W-1:0]      top_in,
        input logic [CRC_W-1:0]      poly_in,
        input logic [EFF_W_BITS-1:0] shift_in
    );
        logic [CRC_W-1:0] c;
        logic             fb;
        if (refl_in)
        begin
            c = crc_in ^ CRC_W'(byte_in);
            for (int k = 0; k < 8; k++)
            begin
                fb = c[0];
                c  = c >> 1;
                if (fb)
                begin
                    c = c ^ poly_in;
                end
            end
        end
        else
        begin
            c = crc_in ^ (CRC_W'(byte_in) << shift_in);
            for (int k = 0; k < 8; k++)
            begin
                fb = |(c & top_in);
                c  = (c << 1) & mask_in;
                if (fb)
                begin
                    c = c ^ poly_in;
                end
            end
        end
        return c & mask_in;
    endfunction

    // Take a request whenever the result queue has room.
    assign fire    = cmd_valid && !out_full;
    assign cmd_pop = fire;

    always_comb
    begin
        crc_start        = (cmd.restart ? init_eff : running_crc_reg) & crc_mask;
        running_crc_next = crc_byte(crc_start, cmd.data_byte, refl, crc_mask,
                                    top_bit, poly_eff, byte_shift);
    end

    // Running CRC carried from one byte to the next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= '0;
        end
        else if (fire)
        begin
            running_crc_reg <= running_crc_next;
        end
    end

    // Results wait here so that the engine need not stall on a slow reader.
    crce_fifo #(
        .WIDTH (CRC_W)
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire),
        .wr_data (running_crc_next),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

    assign crc_value = CRC_OUT_W'(out_data);

endmodule

`default_nettype wire
